// File: rtl/icos_pkg.sv
// Shared types, constants and helper functions of the icosphere subdivider.
`default_nettype none

package icos_pkg;

  localparam int IDX_W      = 12;
  localparam int CNT_W      = 13;
  localparam int COORD_W    = 16;
  localparam int VTX_DEPTH  = 4096;
  localparam int EDGE_DEPTH = 4096;
  localparam int ICO_COUNT  = 12;

  // Icosahedron constants in Q2.14, rounded from Q0.32
  localparam logic signed [COORD_W-1:0] ICO_X = 16'sd8614;
  localparam logic signed [COORD_W-1:0] ICO_Z = 16'sd13937;

  localparam logic [1:0] KIND_VERTEX   = 2'd0;
  localparam logic [1:0] KIND_TRIANGLE = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  localparam logic OP_LEVEL = 1'b0;
  localparam logic OP_SPLIT = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] vtx;
  } edge_t;

  function automatic vec_t ico_vertex(input logic [3:0] idx);
    vec_t v;
    v = '0;
    case (idx)
      4'd0:  v = '{x: -ICO_X, y: 16'sd0, z:  ICO_Z};
      4'd1:  v = '{x:  ICO_X, y: 16'sd0, z:  ICO_Z};
      4'd2:  v = '{x: -ICO_X, y: 16'sd0, z: -ICO_Z};
      4'd3:  v = '{x:  ICO_X, y: 16'sd0, z: -ICO_Z};
      4'd4:  v = '{x: 16'sd0, y:  ICO_Z, z:  ICO_X};
      4'd5:  v = '{x: 16'sd0, y:  ICO_Z, z: -ICO_X};
      4'd6:  v = '{x: 16'sd0, y: -ICO_Z, z:  ICO_X};
      4'd7:  v = '{x: 16'sd0, y: -ICO_Z, z: -ICO_X};
      4'd8:  v = '{x:  ICO_Z, y:  ICO_X, z: 16'sd0};
      4'd9:  v = '{x: -ICO_Z, y:  ICO_X, z: 16'sd0};
      4'd10: v = '{x:  ICO_Z, y: -ICO_X, z: 16'sd0};
      4'd11: v = '{x: -ICO_Z, y: -ICO_X, z: 16'sd0};
      default: v = '0;
    endcase
    return v;
  endfunction

  // Home slot of an edge key in the open-addressed edge table
  function automatic logic [IDX_W-1:0] edge_hash(input logic [IDX_W-1:0] hi,
                                                 input logic [IDX_W-1:0] lo);
    return hi ^ {lo[IDX_W/2-1:0], lo[IDX_W-1:IDX_W/2]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/icos_midpoint.sv
// Normalised midpoint unit: one squarer, bit-serial square root and divider.
`default_nettype none

module icos_midpoint (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire icos_pkg::vec_t vec_p_i,
  input  wire icos_pkg::vec_t vec_q_i,
  output logic               done_o,
  output icos_pkg::vec_t     vec_o
);
  import icos_pkg::*;

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_MUL  = 3'd1;
  localparam logic [2:0] M_SQRT = 3'd2;
  localparam logic [2:0] M_DSET = 3'd3;
  localparam logic [2:0] M_DIV  = 3'd4;
  localparam logic [2:0] M_DFIN = 3'd5;

  logic [2:0]         mst_q;
  logic signed [16:0] sx_q, sy_q, sz_q;
  logic [1:0]         k_q;
  logic [32:0]        prod_q;
  logic [33:0]        acc_q;
  logic [33:0]        res_q;
  logic [33:0]        bit_q;
  logic [16:0]        n_q;
  logic [31:0]        num_q;
  logic [17:0]        rem_q;
  logic [4:0]         cnt_q;
  logic               done_q;
  vec_t               out_q;

  logic signed [16:0] s_cur;
  logic signed [33:0] sq_full;
  logic [34:0]        sqt;
  logic               sq_ge;
  logic [33:0]        res_nx;
  logic [18:0]        div_sh;
  logic [18:0]        div_d;
  logic               div_ge;
  logic [18:0]        div_rem;
  logic signed [17:0] s_ext;
  logic [17:0]        mag;
  logic [31:0]        num_init;
  logic               big;
  logic signed [15:0] coord;

  always_comb begin
    case (k_q)
      2'd0:    s_cur = sx_q;
      2'd1:    s_cur = sy_q;
      2'd2:    s_cur = sz_q;
      default: s_cur = '0;
    endcase
    sq_full  = s_cur * s_cur;
    sqt      = {1'b0, res_q} + {1'b0, bit_q};
    sq_ge    = {1'b0, acc_q} >= sqt;
    res_nx   = sq_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);
    div_sh   = {rem_q, num_q[31]};
    div_d    = {1'b0, n_q, 1'b0};
    div_ge   = div_sh >= div_d;
    div_rem  = div_ge ? (div_sh - div_d) : div_sh;
    s_ext    = {s_cur[16], s_cur};
    mag      = s_cur[16] ? 18'(-s_ext) : 18'(s_ext);
    num_init = {mag[16:0], 15'd0} + {15'd0, n_q};
    big      = |num_q[31:15];
    if (s_cur[16]) begin
      coord = big ? -16'sd32768 : 16'(-$signed({1'b0, num_q[14:0]}));
    end else begin
      coord = big ? 16'sd32767 : $signed({1'b0, num_q[14:0]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mst_q  <= M_IDLE;
      sx_q   <= '0;
      sy_q   <= '0;
      sz_q   <= '0;
      k_q    <= '0;
      prod_q <= '0;
      acc_q  <= '0;
      res_q  <= '0;
      bit_q  <= '0;
      n_q    <= '0;
      num_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
      out_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (mst_q)
        M_IDLE: begin
          if (start_i) begin
            sx_q   <= 17'(vec_p_i.x) + 17'(vec_q_i.x);
            sy_q   <= 17'(vec_p_i.y) + 17'(vec_q_i.y);
            sz_q   <= 17'(vec_p_i.z) + 17'(vec_q_i.z);
            k_q    <= '0;
            prod_q <= '0;
            acc_q  <= '0;
            mst_q  <= M_MUL;
          end
        end
        M_MUL: begin
          // square one sum, accumulate the previous square
          prod_q <= sq_full[32:0];
          acc_q  <= acc_q + {1'b0, prod_q};
          k_q    <= k_q + 2'd1;
          if (k_q == 2'd3) begin
            res_q <= '0;
            bit_q <= 34'd1 << 32;
            mst_q <= M_SQRT;
          end
        end
        M_SQRT: begin
          if (sq_ge) acc_q <= acc_q - sqt[33:0];
          res_q <= res_nx;
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            n_q   <= res_nx[16:0];
            k_q   <= '0;
            mst_q <= M_DSET;
          end
        end
        M_DSET: begin
          if (n_q == '0) begin
            out_q  <= '0;
            done_q <= 1'b1;
            mst_q  <= M_IDLE;
          end else begin
            num_q <= num_init;
            rem_q <= '0;
            cnt_q <= '0;
            mst_q <= M_DIV;
          end
        end
        M_DIV: begin
          rem_q <= div_rem[17:0];
          num_q <= {num_q[30:0], div_ge};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) mst_q <= M_DFIN;
        end
        M_DFIN: begin
          case (k_q)
            2'd0:    out_q.x <= coord;
            2'd1:    out_q.y <= coord;
            default: out_q.z <= coord;
          endcase
          if (k_q == 2'd2) begin
            done_q <= 1'b1;
            mst_q  <= M_IDLE;
          end else begin
            k_q   <= k_q + 2'd1;
            mst_q <= M_DSET;
          end
        end
        default: mst_q <= M_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign vec_o  = out_q;

endmodule

`default_nettype wire

// File: rtl/icosphere_triangle_subdivider.sv
// Icosphere midpoint subdivider: edge table, vertex store and control sequencer.
`default_nettype none

// Splits a triangle of a unit-sphere mesh into four. Vertices 0 to 11 are the
// icosahedron; new midpoints are appended from index 12 and reported as vertex
// beats (kind 0) ahead of the four child triangle beats (kind 1), the final
// beat of an item carrying last_o. A triangle that would overflow the vertex
// store or the edge table gives one error beat (kind 2) and changes nothing.
// Beats appear on valid_o for one cycle each and cannot be held off. After
// reset, and for every level start (operation 0), the block sweeps the 4096
// entry edge table one entry a cycle, holding busy high throughout the sweep.
// A triangle then takes one lookup per edge: the first edge table slot probed
// passes S_PADDR, S_PWAIT and S_PCMP, each further slot S_PWAIT and S_PCMP.
// A new edge adds sequencing and vertex reads (S_NEXT, S_VA to S_VD), the
// midpoint unit (squares, 17 root steps, three 32-step divides) and a second
// probe. The serial midpoint unit and single edge table read port set the rate.
module icosphere_triangle_subdivider (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        operation_i,
  input  wire logic [icos_pkg::IDX_W-1:0]  corner_a_i,
  input  wire logic [icos_pkg::IDX_W-1:0]  corner_b_i,
  input  wire logic [icos_pkg::IDX_W-1:0]  corner_c_i,
  output logic                             valid_o,
  output logic [1:0]                       kind_o,
  output logic [icos_pkg::IDX_W-1:0]       index_a_o,
  output logic [icos_pkg::IDX_W-1:0]       index_b_o,
  output logic [icos_pkg::IDX_W-1:0]       index_c_o,
  output logic signed [icos_pkg::COORD_W-1:0] coord_x_o,
  output logic signed [icos_pkg::COORD_W-1:0] coord_y_o,
  output logic signed [icos_pkg::COORD_W-1:0] coord_z_o,
  output logic                             last_o
);
  import icos_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PADDR = 4'd2;
  localparam logic [3:0] S_PWAIT = 4'd3;
  localparam logic [3:0] S_PCMP  = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_NEXT  = 4'd6;
  localparam logic [3:0] S_VA    = 4'd7;
  localparam logic [3:0] S_VB    = 4'd8;
  localparam logic [3:0] S_VC    = 4'd9;
  localparam logic [3:0] S_VD    = 4'd10;
  localparam logic [3:0] S_MWAIT = 4'd11;
  localparam logic [3:0] S_TRI   = 4'd12;

  // Memories
  edge_t edge_mem [EDGE_DEPTH];
  vec_t  vtx_mem  [VTX_DEPTH];
  edge_t erd_q;
  vec_t  vrd_q;

  logic [3:0]       state_q;
  logic [IDX_W-1:0] clr_q;
  logic [IDX_W-1:0] ca_q, cb_q, cc_q;
  logic [IDX_W-1:0] hi_q [3];
  logic [IDX_W-1:0] lo_q [3];
  logic [IDX_W-1:0] mid_q [3];
  logic [2:0]       found_q;
  logic [2:0]       dup_q;
  logic             src2_q;
  logic [1:0]       j_q;
  logic             ph_q;
  logic [IDX_W-1:0] eaddr_q;
  logic [IDX_W-1:0] pcnt_q;
  logic [IDX_W-1:0] vaddr_q;
  logic [CNT_W-1:0] vcount_q;
  logic [CNT_W-1:0] eused_q;
  logic [1:0]       tri_q;
  vec_t             p_q;
  vec_t             xyz_q;

  logic             valid_q;
  logic [1:0]       kind_q;
  logic [IDX_W-1:0] ia_q, ib_q, ic_q;
  vec_t             co_q;
  logic             last_q;

  logic [IDX_W-1:0] cur_hi, cur_lo;
  logic             cur_new;
  logic [2:0]       isnew;
  logic [1:0]       need;
  logic [CNT_W-1:0] free_v, free_e;
  logic             hit;
  logic             insert;
  logic             ewe;
  logic [IDX_W-1:0] ewaddr;
  edge_t            ewdata;
  vec_t             vsel_hi, vsel_lo;
  logic             mdone;
  vec_t             mvec;
  logic [IDX_W-1:0] hi_d [3];
  logic [IDX_W-1:0] lo_d [3];
  logic [IDX_W-1:0] c_in [3];

  always_comb begin
    c_in[0] = corner_a_i;
    c_in[1] = corner_b_i;
    c_in[2] = corner_c_i;
    for (int e = 0; e < 3; e++) begin
      hi_d[e] = (c_in[e] > c_in[(e + 1) % 3]) ? c_in[e] : c_in[(e + 1) % 3];
      lo_d[e] = (c_in[e] > c_in[(e + 1) % 3]) ? c_in[(e + 1) % 3] : c_in[e];
    end
  end

  always_comb begin
    isnew = ~found_q & ~dup_q;
    case (j_q)
      2'd0:    begin cur_hi = hi_q[0]; cur_lo = lo_q[0]; cur_new = isnew[0]; end
      2'd1:    begin cur_hi = hi_q[1]; cur_lo = lo_q[1]; cur_new = isnew[1]; end
      default: begin cur_hi = hi_q[2]; cur_lo = lo_q[2]; cur_new = isnew[2]; end
    endcase
    need   = 2'({1'b0, isnew[0]} + {1'b0, isnew[1]} + {1'b0, isnew[2]});
    free_v = CNT_W'(VTX_DEPTH) - vcount_q;
    free_e = CNT_W'(EDGE_DEPTH) - eused_q;
    hit    = erd_q.valid && (erd_q.hi == cur_hi) && (erd_q.lo == cur_lo);
    insert = (state_q == S_PCMP) && ph_q && !erd_q.valid;
    vsel_hi = (cur_hi < IDX_W'(ICO_COUNT)) ? ico_vertex(cur_hi[3:0]) : vrd_q;
    vsel_lo = (cur_lo < IDX_W'(ICO_COUNT)) ? ico_vertex(cur_lo[3:0]) : vrd_q;
    ewe    = (state_q == S_CLEAR) || insert;
    ewaddr = (state_q == S_CLEAR) ? clr_q : eaddr_q;
    ewdata = (state_q == S_CLEAR) ? '0 :
             '{valid: 1'b1, hi: cur_hi, lo: cur_lo, vtx: vcount_q[IDX_W-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (ewe) edge_mem[ewaddr] <= ewdata;
    erd_q <= edge_mem[eaddr_q];
  end

  always_ff @(posedge clk_i) begin
    if (insert) vtx_mem[vcount_q[IDX_W-1:0]] <= xyz_q;
    vrd_q <= vtx_mem[vaddr_q];
  end

  icos_midpoint u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_VD),
    .vec_p_i (p_q),
    .vec_q_i (vsel_lo),
    .done_o  (mdone),
    .vec_o   (mvec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      ca_q     <= '0;
      cb_q     <= '0;
      cc_q     <= '0;
      for (int e = 0; e < 3; e++) begin
        hi_q[e]  <= '0;
        lo_q[e]  <= '0;
        mid_q[e] <= '0;
      end
      found_q  <= '0;
      dup_q    <= '0;
      src2_q   <= 1'b0;
      j_q      <= '0;
      ph_q     <= 1'b0;
      eaddr_q  <= '0;
      pcnt_q   <= '0;
      vaddr_q  <= '0;
      vcount_q <= CNT_W'(ICO_COUNT);
      eused_q  <= '0;
      tri_q    <= '0;
      p_q      <= '0;
      xyz_q    <= '0;
      valid_q  <= 1'b0;
      kind_q   <= '0;
      ia_q     <= '0;
      ib_q     <= '0;
      ic_q     <= '0;
      co_q     <= '0;
      last_q   <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            if (operation_i == OP_LEVEL) begin
              eused_q <= '0;
              clr_q   <= '0;
              state_q <= S_CLEAR;
            end else begin
              ca_q <= corner_a_i;
              cb_q <= corner_b_i;
              cc_q <= corner_c_i;
              for (int e = 0; e < 3; e++) begin
                hi_q[e] <= hi_d[e];
                lo_q[e] <= lo_d[e];
              end
              dup_q[0] <= 1'b0;
              dup_q[1] <= (hi_d[1] == hi_d[0]) && (lo_d[1] == lo_d[0]);
              dup_q[2] <= ((hi_d[2] == hi_d[0]) && (lo_d[2] == lo_d[0])) ||
                          ((hi_d[2] == hi_d[1]) && (lo_d[2] == lo_d[1]));
              src2_q   <= !((hi_d[2] == hi_d[0]) && (lo_d[2] == lo_d[0]));
              found_q  <= '0;
              j_q      <= '0;
              ph_q     <= 1'b0;
              state_q  <= S_PADDR;
            end
          end
        end
        S_PADDR: begin
          eaddr_q <= edge_hash(cur_hi, cur_lo);
          pcnt_q  <= '0;
          state_q <= S_PWAIT;
        end
        S_PWAIT: state_q <= S_PCMP;
        S_PCMP: begin
          if (!ph_q) begin
            if (hit || !erd_q.valid || pcnt_q == '1) begin
              found_q[j_q] <= hit;
              if (hit) mid_q[j_q] <= erd_q.vtx;
              if (j_q == 2'd2) begin
                state_q <= S_CHECK;
              end else begin
                j_q     <= j_q + 2'd1;
                state_q <= S_PADDR;
              end
            end else begin
              eaddr_q <= eaddr_q + 1'b1;
              pcnt_q  <= pcnt_q + 1'b1;
              state_q <= S_PWAIT;
            end
          end else if (!erd_q.valid || pcnt_q == '1) begin
            // store the new edge and its vertex, send the vertex beat
            if (!erd_q.valid) begin
              mid_q[j_q] <= vcount_q[IDX_W-1:0];
              vcount_q   <= vcount_q + 1'b1;
              eused_q    <= eused_q + 1'b1;
              valid_q    <= 1'b1;
              kind_q     <= KIND_VERTEX;
              ia_q       <= vcount_q[IDX_W-1:0];
              ib_q       <= '0;
              ic_q       <= '0;
              co_q       <= xyz_q;
              last_q     <= 1'b0;
            end
            j_q     <= j_q + 2'd1;
            state_q <= S_NEXT;
          end else begin
            eaddr_q <= eaddr_q + 1'b1;
            pcnt_q  <= pcnt_q + 1'b1;
            state_q <= S_PWAIT;
          end
        end
        S_CHECK: begin
          if ({{(CNT_W-2){1'b0}}, need} > free_v ||
              {{(CNT_W-2){1'b0}}, need} > free_e) begin
            valid_q <= 1'b1;
            kind_q  <= KIND_ERROR;
            ia_q    <= '0;
            ib_q    <= '0;
            ic_q    <= '0;
            co_q    <= '0;
            last_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            j_q     <= '0;
            ph_q    <= 1'b1;
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (j_q == 2'd3) begin
            tri_q   <= '0;
            state_q <= S_TRI;
          end else if (cur_new) begin
            state_q <= S_VA;
          end else begin
            // repeated edge within the triangle: take the earlier midpoint
            if (j_q == 2'd1 && dup_q[1]) mid_q[1] <= mid_q[0];
            if (j_q == 2'd2 && dup_q[2]) mid_q[2] <= src2_q ? mid_q[1] : mid_q[0];
            j_q <= j_q + 2'd1;
          end
        end
        S_VA: begin
          vaddr_q <= cur_hi;
          state_q <= S_VB;
        end
        S_VB: begin
          vaddr_q <= cur_lo;
          state_q <= S_VC;
        end
        S_VC: begin
          p_q     <= vsel_hi;
          state_q <= S_VD;
        end
        S_VD: state_q <= S_MWAIT;
        S_MWAIT: begin
          if (mdone) begin
            xyz_q   <= mvec;
            state_q <= S_PADDR;
          end
        end
        S_TRI: begin
          valid_q <= 1'b1;
          kind_q  <= KIND_TRIANGLE;
          co_q    <= '0;
          last_q  <= (tri_q == 2'd3);
          case (tri_q)
            2'd0:    begin ia_q <= ca_q;     ib_q <= mid_q[0]; ic_q <= mid_q[2]; end
            2'd1:    begin ia_q <= cb_q;     ib_q <= mid_q[1]; ic_q <= mid_q[0]; end
            2'd2:    begin ia_q <= cc_q;     ib_q <= mid_q[2]; ic_q <= mid_q[1]; end
            default: begin ia_q <= mid_q[0]; ib_q <= mid_q[1]; ic_q <= mid_q[2]; end
          endcase
          tri_q <= tri_q + 2'd1;
          if (tri_q == 2'd3) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_q != S_IDLE);
  assign valid_o   = valid_q;
  assign kind_o    = kind_q;
  assign index_a_o = ia_q;
  assign index_b_o = ib_q;
  assign index_c_o = ic_q;
  assign coord_x_o = co_q.x;
  assign coord_y_o = co_q.y;
  assign coord_z_o = co_q.z;
  assign last_o    = last_q;

endmodule

`default_nettype wire

// File: rtl/icos_checker.sv
// Port-level checks of the subdivider and their binding to the top level.
`default_nettype none

module icos_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       valid_o,
  input wire logic [1:0]                 kind_o,
  input wire logic [icos_pkg::IDX_W-1:0] index_b_o,
  input wire logic [icos_pkg::IDX_W-1:0] index_c_o,
  input wire logic                       last_o
);
  import icos_pkg::*;

  // an accepted beat always starts a busy stretch
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy low after accepted start");

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o == KIND_ERROR |-> last_o)
    else $error("error beat without last");

  a_quiet_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !valid_o)
    else $error("beat right after last");

  a_vertex_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o == KIND_VERTEX |-> index_b_o == '0 && index_c_o == '0 && !last_o)
    else $error("malformed vertex beat");

endmodule

bind icosphere_triangle_subdivider icos_checker u_icos_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .valid_o   (valid_o),
  .kind_o    (kind_o),
  .index_b_o (index_b_o),
  .index_c_o (index_c_o),
  .last_o    (last_o)
);

`default_nettype wire

// File: tb/icosphere_subdivider_checker.sv
// Checker for the icosphere subdivider: tracks the mesh, predicts beats and compares them.
`timescale 1ns / 1ps

module icosphere_subdivider_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic                         busy_i,
  input  wire logic                         operation_i,
  input  wire logic [icos_pkg::IDX_W-1:0]   corner_a_i,
  input  wire logic [icos_pkg::IDX_W-1:0]   corner_b_i,
  input  wire logic [icos_pkg::IDX_W-1:0]   corner_c_i,
  input  wire logic                         valid_i,
  input  wire logic [1:0]                   kind_i,
  input  wire logic [icos_pkg::IDX_W-1:0]   index_a_i,
  input  wire logic [icos_pkg::IDX_W-1:0]   index_b_i,
  input  wire logic [icos_pkg::IDX_W-1:0]   index_c_i,
  input  wire logic [icos_pkg::COORD_W-1:0] coord_x_i,
  input  wire logic [icos_pkg::COORD_W-1:0] coord_y_i,
  input  wire logic [icos_pkg::COORD_W-1:0] coord_z_i,
  input  wire logic                         last_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                vertex_total_o
);
  import icos_pkg::*;

  typedef struct packed {
    logic [1:0]         kind;
    logic [IDX_W-1:0]   a;
    logic [IDX_W-1:0]   b;
    logic [IDX_W-1:0]   c;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               last;
  } mesh_beat_t;

  mesh_beat_t expected_beats[$];
  vec_t       mesh_vertices[VTX_DEPTH];
  int         vertex_total;
  int         edge_hi[EDGE_DEPTH];
  int         edge_lo[EDGE_DEPTH];
  int         edge_mid[EDGE_DEPTH];
  int         edge_total;

  assign vertex_total_o = vertex_total;

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  function automatic logic [COORD_W-1:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[COORD_W-1:0];
  endfunction

  function automatic vec_t normalised_midpoint(input int p, input int q);
    longint s[3];
    longint unsigned sq, n, mag, r;
    logic [COORD_W-1:0] o[3];
    vec_t vp, vq, res;
    vp = mesh_vertices[p];
    vq = mesh_vertices[q];
    s[0] = longint'(vp.x) + longint'(vq.x);
    s[1] = longint'(vp.y) + longint'(vq.y);
    s[2] = longint'(vp.z) + longint'(vq.z);
    sq = 0;
    for (int k = 0; k < 3; k++) sq += s[k] * s[k];
    n = root_floor(sq);
    for (int k = 0; k < 3; k++) begin
      if (n == 0) begin
        o[k] = '0;
      end else begin
        mag = s[k] < 0 ? -s[k] : s[k];
        r = ((mag << 14) * 2 + n) / (2 * n);
        if (r > 40000) r = 40000;
        o[k] = clamp16(s[k] < 0 ? -longint'(r) : longint'(r));
      end
    end
    res.x = o[0];
    res.y = o[1];
    res.z = o[2];
    return res;
  endfunction

  function automatic int lookup_edge(input int hi, input int lo);
    for (int i = 0; i < edge_total; i++)
      if (edge_hi[i] == hi && edge_lo[i] == lo) return edge_mid[i];
    return -1;
  endfunction

  function automatic void push_beat(input logic [1:0] kind, input int a, input int b,
                                    input int c, input vec_t v, input logic last);
    mesh_beat_t e;
    e.kind = kind;
    e.a = a[IDX_W-1:0];
    e.b = b[IDX_W-1:0];
    e.c = c[IDX_W-1:0];
    e.x = v.x;
    e.y = v.y;
    e.z = v.z;
    e.last = last;
    expected_beats.insert(expected_beats.size(), e);
  endfunction

  function automatic void split_triangle(input int ca, input int cb, input int cc);
    int corner[3], hi[3], lo[3], mid[3];
    int need, w;
    bit fresh;
    vec_t v;
    corner[0] = ca;
    corner[1] = cb;
    corner[2] = cc;
    need = 0;
    for (int j = 0; j < 3; j++) begin
      hi[j] = corner[j] > corner[(j+1)%3] ? corner[j] : corner[(j+1)%3];
      lo[j] = corner[j] > corner[(j+1)%3] ? corner[(j+1)%3] : corner[j];
      fresh = lookup_edge(hi[j], lo[j]) < 0;
      for (int d = 0; d < j; d++)
        if (hi[d] == hi[j] && lo[d] == lo[j]) fresh = 0;
      if (fresh) need++;
    end
    if (need > VTX_DEPTH - vertex_total || need > EDGE_DEPTH - edge_total) begin
      push_beat(KIND_ERROR, 0, 0, 0, '0, 1'b1);
      return;
    end
    for (int j = 0; j < 3; j++) begin
      mid[j] = lookup_edge(hi[j], lo[j]);
      if (mid[j] < 0) begin
        w = vertex_total;
        v = normalised_midpoint(hi[j], lo[j]);
        mesh_vertices[w] = v;
        vertex_total++;
        edge_hi[edge_total] = hi[j];
        edge_lo[edge_total] = lo[j];
        edge_mid[edge_total] = w;
        edge_total++;
        mid[j] = w;
        push_beat(KIND_VERTEX, w, 0, 0, v, 1'b0);
      end
    end
    push_beat(KIND_TRIANGLE, corner[0], mid[0], mid[2], '0, 1'b0);
    push_beat(KIND_TRIANGLE, corner[1], mid[1], mid[0], '0, 1'b0);
    push_beat(KIND_TRIANGLE, corner[2], mid[2], mid[1], '0, 1'b0);
    push_beat(KIND_TRIANGLE, mid[0], mid[1], mid[2], '0, 1'b1);
  endfunction

  function automatic void seed_icosahedron();
    int pat[12][3] = '{'{-1, 0, 2}, '{1, 0, 2}, '{-1, 0, -2}, '{1, 0, -2},
                       '{0, 2, 1}, '{0, 2, -1}, '{0, -2, 1}, '{0, -2, -1},
                       '{2, 1, 0}, '{-2, 1, 0}, '{2, -1, 0}, '{-2, -1, 0}};
    logic [COORD_W-1:0] c[3];
    foreach (mesh_vertices[i]) mesh_vertices[i] = '0;
    for (int i = 0; i < ICO_COUNT; i++) begin
      for (int k = 0; k < 3; k++) begin
        case (pat[i][k])
          -2: c[k] = -ICO_Z;
          -1: c[k] = -ICO_X;
          1:  c[k] = ICO_X;
          2:  c[k] = ICO_Z;
          default: c[k] = '0;
        endcase
      end
      mesh_vertices[i] = '{x: c[0], y: c[1], z: c[2]};
    end
    vertex_total = ICO_COUNT;
    edge_total = 0;
  endfunction

  initial begin
    fail_count_o = 0;
    seed_icosahedron();
  end

  always @(posedge clk_i) begin
    mesh_beat_t got, want;
    if (rst_ni) begin
      if (valid_i) begin
        got = '{kind_i, index_a_i, index_b_i, index_c_i, coord_x_i, coord_y_i, coord_z_i,
                last_i};
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %p", $time, got);
          fail_count_o++;
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            $display("%0t: beat mismatch, expected %p, actual %p", $time, want, got);
            fail_count_o++;
          end
        end
      end
      // predict after comparing: a new item's beats never share its accepting edge
      if (start_i && !busy_i) begin
        if (operation_i == OP_LEVEL) edge_total = 0;
        else split_triangle(corner_a_i, corner_b_i, corner_c_i);
      end
    end
    pending_o = expected_beats.size();
  end

endmodule

// File: tb/tb_icosphere_triangle_subdivider.sv
// Testbench top for the icosphere subdivider: stimulus, checker hookup and verdict.
`timescale 1ns / 1ps

module tb_icosphere_triangle_subdivider;
  import icos_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               operation_i = OP_SPLIT;
  logic [IDX_W-1:0]   corner_a_i = '0;
  logic [IDX_W-1:0]   corner_b_i = '0;
  logic [IDX_W-1:0]   corner_c_i = '0;
  logic               valid_o;
  logic [1:0]         kind_o;
  logic [IDX_W-1:0]   index_a_o, index_b_o, index_c_o;
  logic [COORD_W-1:0] coord_x_o, coord_y_o, coord_z_o;
  logic               last_o;
  int                 fail_count, pending, vertex_total;
  int                 burst_left = 0;
  int                 prev_a = 0, prev_b = 1, prev_c = 4;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  icosphere_triangle_subdivider dut (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .corner_a_i, .corner_b_i, .corner_c_i,
    .valid_o, .kind_o, .index_a_o, .index_b_o, .index_c_o, .coord_x_o, .coord_y_o,
    .coord_z_o, .last_o
  );

  icosphere_subdivider_checker mesh_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .operation_i, .corner_a_i,
    .corner_b_i, .corner_c_i, .valid_i(valid_o), .kind_i(kind_o), .index_a_i(index_a_o),
    .index_b_i(index_b_o), .index_c_i(index_c_o), .coord_x_i(coord_x_o),
    .coord_y_i(coord_y_o), .coord_z_i(coord_z_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending), .vertex_total_o(vertex_total)
  );

  // Drive one beat and hold it until accepted; gaps fall between bursts
  task automatic send_beat(input logic op, input int a, input int b, input int c);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1'b1;
    operation_i <= op;
    corner_a_i <= a[IDX_W-1:0];
    corner_b_i <= b[IDX_W-1:0];
    corner_c_i <= c[IDX_W-1:0];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (op == OP_SPLIT) begin
      prev_a = a;
      prev_b = b;
      prev_c = c;
    end
  endtask

  task automatic split_random();
    int top_idx, a, b, c;
    top_idx = vertex_total - 1;
    c = $urandom_range(0, top_idx);
    case ($urandom_range(0, 3))
      0, 1: begin
        // neighbour across a shared edge, walked the other way
        a = prev_b;
        b = prev_a;
      end
      2: begin
        a = $urandom_range(0, top_idx);
        b = $urandom_range(0, top_idx);
      end
      default: begin
        a = $urandom_range(0, top_idx);
        b = a;
      end
    endcase
    send_beat(OP_SPLIT, a, b, c);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_beat(OP_LEVEL, 0, 0, 0);
    send_beat(OP_SPLIT, 0, 1, 4);
    send_beat(OP_SPLIT, 0, 1, 4);
    send_beat(OP_SPLIT, 4, 1, 0);
    send_beat(OP_SPLIT, 0, 3, 5);
    send_beat(OP_SPLIT, 9, 8, 2);
    send_beat(OP_SPLIT, 0, 0, 0);
    send_beat(OP_SPLIT, 11, 11, 0);
    send_beat(OP_SPLIT, 18, 18, 3);
    send_beat(OP_SPLIT, 18, 7, 6);
    send_beat(OP_LEVEL, 4095, 4095, 4095);
    send_beat(OP_SPLIT, 0, 1, 4);
    send_beat(OP_SPLIT, 10, 11, 7);
    send_beat(OP_SPLIT, 2, 3, 5);

    for (int i = 0; i < 444; i++) begin
      if ($urandom_range(0, 59) == 0)
        send_beat(OP_LEVEL, $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 4095));
      else
        split_random();
    end

    for (int i = 0; i < 12; i++) begin
      if (i % 4 == 3) send_beat(OP_SPLIT, prev_a, prev_b, prev_c);
      else split_random();
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #60ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: sim.f
rtl/icos_pkg.sv
rtl/icos_midpoint.sv
rtl/icosphere_triangle_subdivider.sv
rtl/icos_checker.sv
tb/icosphere_subdivider_checker.sv
tb/tb_icosphere_triangle_subdivider.sv
